/* hdl/astar_pkg.sv */
// Shared constants, types and controller/datapath interface structs for the A* search block.
package astar_pkg;

    localparam int VERTEX_COUNT = 26;
    localparam int MAX_EDGES    = 256;

    localparam int VW      = $clog2(VERTEX_COUNT);
    localparam int QW      = $clog2(VERTEX_COUNT + 1);
    localparam int EAW     = $clog2(MAX_EDGES);
    localparam int ECW     = $clog2(MAX_EDGES + 1);
    localparam int WGT_W   = 16;
    localparam int COST_W  = 21;
    localparam int F_W     = COST_W + 1;

    localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};
    localparam logic [COST_W-1:0] COST_SAT = {{(COST_W-1){1'b1}}, 1'b0};

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic REG_START = 1'b0;
    localparam logic REG_GOAL  = 1'b1;

    typedef struct packed {
        logic [4:0]       src;
        logic [4:0]       tgt;
        logic [WGT_W-1:0] weight;
    } edge_t;

    typedef struct packed {
        logic add_edge;
        logic clear_edges;
        logic init;
        logic scan_step;
        logic pick;
        logic edge_step;
        logic walk_start;
        logic walk_step;
        logic emit_step;
        logic emit_fail;
    } dp_cmd_t;

    typedef struct packed {
        logic bad_cfg;
        logic scan_last;
        logic goal_hit;
        logic edge_done;
        logic qlen_zero;
        logic walk_done;
        logic emit_last;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/astar_ctrl.sv */
// Sequencing state machine for edge loading, search, path walk and emission.
module astar_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  astar_pkg::dp_status_t status,
    output astar_pkg::dp_cmd_t    cmd
);
    import astar_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_PICK = 7'b0000100,
        ST_EDGE = 7'b0001000,
        ST_WALK = 7'b0010000,
        ST_EMIT = 7'b0100000,
        ST_FAIL = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // The unused command code is taken and dropped.
                    unique case (command)
                        CMD_ADD:
                        begin
                            cmd.add_edge = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            cmd.clear_edges = 1'b1;
                        end
                        CMD_SEARCH:
                        begin
                            if (status.bad_cfg)
                            begin
                                state_next = ST_FAIL;
                            end
                            else
                            begin
                                cmd.init   = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (status.goal_hit)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = ST_WALK;
                end
                else
                begin
                    cmd.pick   = 1'b1;
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                if (status.edge_done)
                begin
                    state_next = status.qlen_zero ? ST_FAIL : ST_SCAN;
                end
                else
                begin
                    cmd.edge_step = 1'b1;
                end
            end
            ST_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FAIL:
            begin
                if (status.out_free)
                begin
                    cmd.emit_fail = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/astar_dp.sv */
// Datapath: edge store, vertex costs and parents, open list, path buffer and result register.
module astar_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  astar_pkg::dp_cmd_t    cmd,
    output astar_pkg::dp_status_t status,
    input  logic [4:0]            start_vertex,
    input  logic [4:0]            goal_vertex,
    input  logic [4:0]            edge_source,
    input  logic [4:0]            edge_target,
    input  logic [15:0]           edge_weight,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [4:0]            path_vertex,
    output logic                  found,
    output logic                  last
);
    import astar_pkg::*;

    // Edge store and its registered read port.
    edge_t           edge_mem [MAX_EDGES];
    edge_t           edge_rd_reg;
    logic [ECW-1:0]  edge_count_reg;
    logic [ECW-1:0]  issue_reg;
    logic            pend_reg;

    // Per-vertex search state; a clear valid bit reads as infinity or no parent.
    logic [COST_W-1:0] cost_reg [VERTEX_COUNT];
    logic [VERTEX_COUNT-1:0] cost_vld_reg;
    logic [VW-1:0]     parent_reg [VERTEX_COUNT];
    logic [VERTEX_COUNT-1:0] parent_vld_reg;

    // Open list in insertion order, with a membership flag per vertex.
    logic [VW-1:0]     open_q_reg [VERTEX_COUNT];
    logic [VERTEX_COUNT-1:0] open_flag_reg;
    logic [QW-1:0]     qlen_reg;

    logic [VW-1:0]     scan_idx_reg;
    logic [VW-1:0]     best_idx_reg;
    logic [F_W-1:0]    bestf_reg;
    logic [COST_W-1:0] bestcost_reg;
    logic [VW-1:0]     cur_reg;
    logic [COST_W-1:0] cur_cost_reg;

    logic [VW-1:0]     path_buf_reg [VERTEX_COUNT];
    logic [QW-1:0]     n_reg;
    logic [VW-1:0]     walk_v_reg;
    logic              walk_vld_reg;

    logic              out_valid_reg;
    logic [VW-1:0]     out_vertex_reg;
    logic              out_found_reg;
    logic              out_last_reg;

    logic [VW-1:0]     scan_v;
    logic [VW-1:0]     cost_addr;
    logic [COST_W-1:0] cost_rd;
    logic [VW-1:0]     goal_gap;
    logic [F_W-1:0]    scan_f;
    logic [VW-1:0]     pick_v;
    logic [VW-1:0]     edge_t_v;
    logic [F_W-1:0]    tent_sum;
    logic [COST_W-1:0] tent;
    logic              relax;
    logic              add_ok;

    assign scan_v    = open_q_reg[scan_idx_reg];
    assign edge_t_v  = edge_rd_reg.tgt[VW-1:0];
    assign cost_addr = pend_reg ? edge_t_v : scan_v;
    assign cost_rd   = cost_vld_reg[cost_addr] ? cost_reg[cost_addr] : COST_INF;
    assign goal_gap  = (goal_vertex[VW-1:0] > scan_v) ? (goal_vertex[VW-1:0] - scan_v)
                                                      : (scan_v - goal_vertex[VW-1:0]);
    assign scan_f    = {1'b0, cost_rd} + F_W'(goal_gap);
    assign pick_v    = open_q_reg[best_idx_reg];

    assign tent_sum  = {1'b0, cur_cost_reg} + F_W'(edge_rd_reg.weight);
    assign tent      = (tent_sum > F_W'(COST_SAT)) ? COST_SAT : tent_sum[COST_W-1:0];
    assign relax     = pend_reg && (edge_rd_reg.src[VW-1:0] == cur_reg) && (tent < cost_rd);

    assign add_ok    = (edge_count_reg < ECW'(MAX_EDGES))
                    && (edge_source < 5'(VERTEX_COUNT)) && (edge_target < 5'(VERTEX_COUNT));

    assign status.bad_cfg   = (start_vertex >= 5'(VERTEX_COUNT))
                           || (goal_vertex >= 5'(VERTEX_COUNT));
    assign status.scan_last = (QW'(scan_idx_reg) + QW'(1)) >= qlen_reg;
    assign status.goal_hit  = (pick_v == goal_vertex[VW-1:0]);
    assign status.edge_done = (issue_reg >= edge_count_reg) && !pend_reg;
    assign status.qlen_zero = (qlen_reg == '0);
    assign status.walk_done = !walk_vld_reg || (n_reg == QW'(VERTEX_COUNT));
    assign status.emit_last = (n_reg == QW'(1));
    assign status.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.add_edge && add_ok)
        begin
            edge_mem[edge_count_reg[EAW-1:0]] <= '{src: edge_source, tgt: edge_target,
                                                   weight: edge_weight};
        end
        edge_rd_reg <= edge_mem[issue_reg[EAW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg <= '0;
            issue_reg      <= '0;
            pend_reg       <= 1'b0;
            cost_vld_reg   <= '0;
            parent_vld_reg <= '0;
            open_flag_reg  <= '0;
            qlen_reg       <= '0;
            walk_vld_reg   <= 1'b0;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.add_edge && add_ok)
            begin
                edge_count_reg <= edge_count_reg + ECW'(1);
            end
            if (cmd.clear_edges)
            begin
                edge_count_reg <= '0;
            end

            if (cmd.init)
            begin
                cost_vld_reg   <= VERTEX_COUNT'(1) << start_vertex[VW-1:0];
                parent_vld_reg <= '0;
                open_flag_reg  <= VERTEX_COUNT'(1) << start_vertex[VW-1:0];
                qlen_reg       <= QW'(1);
            end

            if (cmd.pick)
            begin
                open_flag_reg[pick_v] <= 1'b0;
                qlen_reg              <= qlen_reg - QW'(1);
                issue_reg             <= '0;
                pend_reg              <= 1'b0;
            end

            if (cmd.edge_step)
            begin
                if (issue_reg < edge_count_reg)
                begin
                    issue_reg <= issue_reg + ECW'(1);
                    pend_reg  <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end

            if (relax)
            begin
                cost_vld_reg[edge_t_v]   <= 1'b1;
                parent_vld_reg[edge_t_v] <= 1'b1;
                if (!open_flag_reg[edge_t_v] && (qlen_reg < QW'(VERTEX_COUNT)))
                begin
                    open_flag_reg[edge_t_v] <= 1'b1;
                    qlen_reg                <= qlen_reg + QW'(1);
                end
            end

            if (cmd.walk_start)
            begin
                walk_vld_reg <= 1'b1;
                n_reg        <= '0;
            end
            if (cmd.walk_step)
            begin
                walk_vld_reg <= parent_vld_reg[walk_v_reg];
                n_reg        <= n_reg + QW'(1);
            end
            if (cmd.emit_step)
            begin
                n_reg <= n_reg - QW'(1);
            end

            if (cmd.emit_step || cmd.emit_fail)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            cost_reg[start_vertex[VW-1:0]]   <= '0;
            open_q_reg[0]                    <= start_vertex[VW-1:0];
            scan_idx_reg                     <= '0;
        end
        if (cmd.scan_step)
        begin
            if ((scan_idx_reg == '0) || (scan_f < bestf_reg))
            begin
                bestf_reg    <= scan_f;
                best_idx_reg <= scan_idx_reg;
                bestcost_reg <= cost_rd;
            end
            scan_idx_reg <= scan_idx_reg + VW'(1);
        end
        if (cmd.pick)
        begin
            cur_reg      <= pick_v;
            cur_cost_reg <= bestcost_reg;
            scan_idx_reg <= '0;
            // Close the gap left by the removed entry.
            for (int i = 0; i < VERTEX_COUNT - 1; i++)
            begin
                if (VW'(i) >= best_idx_reg)
                begin
                    open_q_reg[i] <= open_q_reg[i+1];
                end
            end
        end
        if (relax)
        begin
            cost_reg[edge_t_v]   <= tent;
            parent_reg[edge_t_v] <= cur_reg;
            if (!open_flag_reg[edge_t_v] && (qlen_reg < QW'(VERTEX_COUNT)))
            begin
                open_q_reg[qlen_reg[VW-1:0]] <= edge_t_v;
            end
        end
        if (cmd.walk_start)
        begin
            walk_v_reg <= goal_vertex[VW-1:0];
        end
        if (cmd.walk_step)
        begin
            path_buf_reg[n_reg[VW-1:0]] <= walk_v_reg;
            walk_v_reg                  <= parent_reg[walk_v_reg];
        end
        if (cmd.emit_step)
        begin
            out_vertex_reg <= path_buf_reg[n_reg[VW-1:0] - VW'(1)];
            out_found_reg  <= 1'b1;
            out_last_reg   <= (n_reg == QW'(1));
        end
        if (cmd.emit_fail)
        begin
            out_vertex_reg <= '0;
            out_found_reg  <= 1'b0;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign path_vertex = 5'(out_vertex_reg);
    assign found       = out_found_reg;
    assign last        = out_last_reg;

    a_qlen_range: assert property (@(posedge clk) disable iff (!rst_n)
        qlen_reg <= QW'(VERTEX_COUNT))
        else $error("open list length out of range");

    a_open_flags: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(open_flag_reg) == int'(qlen_reg))
        else $error("open flags disagree with open list length");

    a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= ECW'(MAX_EDGES))
        else $error("edge count beyond store capacity");

endmodule

/* hdl/astar_shortest_path_search.sv */
// Top level of the A* shortest path search block: configuration registers and wiring.
//
// Add and clear requests are handled without leaving the idle state. A search request scans
// the open list one entry a cycle to find the smallest priority, then walks the whole edge
// store through its single registered read port, one edge a cycle, for every vertex it
// expands; it then walks the parent links back from the goal, and the path is delivered one
// vertex per cycle as the output side takes it. New requests are taken only between
// searches. An unreachable goal, or a start or goal vertex of 26 or more, gives a single
// result with found clear.
module astar_shortest_path_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [4:0]  edge_source,
    input  logic [4:0]  edge_target,
    input  logic [15:0] edge_weight,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  path_vertex,
    output logic        found,
    output logic        last
);
    import astar_pkg::*;

    logic [4:0] start_reg;
    logic [4:0] goal_reg;
    dp_cmd_t    cmd;
    dp_status_t status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GOAL) ? {27'd0, goal_reg} : {27'd0, start_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            goal_reg  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_START)
            begin
                start_reg <= pwdata[4:0];
            end
            else
            begin
                goal_reg <= pwdata[4:0];
            end
        end
    end

    astar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .status   (status),
        .cmd      (cmd)
    );

    astar_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .start_vertex (start_reg),
        .goal_vertex  (goal_reg),
        .edge_source  (edge_source),
        .edge_target  (edge_target),
        .edge_weight  (edge_weight),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .path_vertex  (path_vertex),
        .found        (found),
        .last         (last)
    );

endmodule

/* bench/astar_shortest_path_search_tb.sv */
// Testbench for the A* search block: directed and random requests against a path predictor.
`timescale 1ns / 1ps
module astar_shortest_path_search_tb;
    import astar_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [4:0]  edge_source;
    logic [4:0]  edge_target;
    logic [15:0] edge_weight;
    logic        out_valid;
    logic        out_ready;
    logic [4:0]  path_vertex;
    logic        found;
    logic        last;

    typedef struct packed {
        logic [4:0] vtx;
        logic       fnd;
        logic       lst;
    } path_step_t;

    localparam logic [2:0] ADDR_START = 3'd0;
    localparam logic [2:0] ADDR_GOAL  = 3'd4;
    localparam logic [1:0] CMD_NONE   = 2'd3;
    localparam int         CYCLE_LIMIT = 3000000;

    path_step_t  expected_path[$];
    logic [4:0]  graph_src[MAX_EDGES];
    logic [4:0]  graph_tgt[MAX_EDGES];
    logic [15:0] graph_wgt[MAX_EDGES];
    int          graph_edges;
    logic [4:0]  cfg_start;
    logic [4:0]  cfg_goal;
    int          sender_idle;
    int          receiver_idle;
    int          hold_cycles;
    int          errors;
    int          cycles;

    astar_shortest_path_search uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .edge_source(edge_source), .edge_target(edge_target), .edge_weight(edge_weight),
        .out_valid(out_valid), .out_ready(out_ready), .path_vertex(path_vertex),
        .found(found), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Runs A* over the local copy of the edge store and queues the path it should emit.
    task automatic predict_search_path();
        logic [20:0] cost[VERTEX_COUNT];
        int          parent[VERTEX_COUNT];
        int          open_list[$];
        int          best;
        int          cur;
        int          gap;
        int          n;
        int          v;
        int          path[$];
        logic [21:0] f;
        logic [21:0] bestf;
        logic [21:0] tent;
        logic        reached;
        logic        listed;
        path_step_t  step;
        reached = 1'b0;
        for (int i = 0; i < VERTEX_COUNT; i++)
        begin
            cost[i] = COST_INF;
            parent[i] = -1;
        end
        if (cfg_start < VERTEX_COUNT && cfg_goal < VERTEX_COUNT)
        begin
            cost[cfg_start] = '0;
            open_list.insert(open_list.size(), cfg_start);
            while (open_list.size() != 0 && !reached)
            begin
                best = 0;
                for (int i = 0; i < open_list.size(); i++)
                begin
                    gap = (cfg_goal > open_list[i]) ? cfg_goal - open_list[i]
                                                    : open_list[i] - cfg_goal;
                    f = cost[open_list[i]] + gap;
                    if (i == 0 || f < bestf)
                    begin
                        bestf = f;
                        best = i;
                    end
                end
                cur = open_list[best];
                if (cur == cfg_goal)
                    reached = 1'b1;
                else
                begin
                    open_list.delete(best);
                    for (int e = 0; e < graph_edges; e++)
                    begin
                        if (graph_src[e] == cur)
                        begin
                            tent = cost[cur] + graph_wgt[e];
                            if (tent > COST_SAT)
                                tent = COST_SAT;
                            if (tent < cost[graph_tgt[e]])
                            begin
                                cost[graph_tgt[e]] = tent[20:0];
                                parent[graph_tgt[e]] = cur;
                                listed = 1'b0;
                                foreach (open_list[k])
                                    if (open_list[k] == graph_tgt[e])
                                        listed = 1'b1;
                                if (!listed && open_list.size() < VERTEX_COUNT)
                                    open_list.insert(open_list.size(), graph_tgt[e]);
                            end
                        end
                    end
                end
            end
        end
        if (!reached)
        begin
            step.vtx = 5'd0;
            step.fnd = 1'b0;
            step.lst = 1'b1;
            expected_path.insert(expected_path.size(), step);
        end
        else
        begin
            n = 0;
            v = cfg_goal;
            while (v >= 0 && n < VERTEX_COUNT)
            begin
                path.push_front(v);
                v = parent[v];
                n++;
            end
            foreach (path[k])
            begin
                step.vtx = path[k][4:0];
                step.fnd = 1'b1;
                step.lst = (k == path.size() - 1);
                expected_path.insert(expected_path.size(), step);
            end
        end
    endtask

    // Leaves the request line high between back-to-back requests; it drops only when idling.
    task automatic send_request(input logic [1:0] cmd, input logic [4:0] src,
                                input logic [4:0] tgt, input logic [15:0] wgt);
        if ($urandom_range(99) < sender_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < sender_idle)
                @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        edge_source <= src;
        edge_target <= tgt;
        edge_weight <= wgt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (cmd)
            CMD_ADD:
                if (graph_edges < MAX_EDGES && src < VERTEX_COUNT && tgt < VERTEX_COUNT)
                begin
                    graph_src[graph_edges] = src;
                    graph_tgt[graph_edges] = tgt;
                    graph_wgt[graph_edges] = wgt;
                    graph_edges++;
                end
            CMD_CLEAR:
                graph_edges = 0;
            CMD_SEARCH:
                predict_search_path();
            default:
                ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_path.size() != 0)
            @(negedge clk);
        repeat (20)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [4:0] value);
        wait_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {27'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_START)
            cfg_start = value;
        else
            cfg_goal = value;
    endtask

    task automatic set_endpoints(input logic [4:0] s, input logic [4:0] g);
        write_register(ADDR_START, s);
        write_register(ADDR_GOAL, g);
    endtask

    // A graph with a cheap detour that beats the direct edge, plus out-of-range edges and endpoints.
    task automatic test_directed();
        set_endpoints(5'd0, 5'd25);
        send_request(CMD_SEARCH, 5'd0, 5'd0, 16'd0);
        send_request(CMD_ADD, 5'd0, 5'd25, 16'hFFFF);
        send_request(CMD_ADD, 5'd0, 5'd1, 16'd1);
        send_request(CMD_ADD, 5'd1, 5'd2, 16'd0);
        send_request(CMD_ADD, 5'd2, 5'd25, 16'd5);
        send_request(CMD_ADD, 5'd0, 5'd3, 16'd9);
        send_request(CMD_ADD, 5'd3, 5'd2, 16'd0);
        send_request(CMD_ADD, 5'd31, 5'd2, 16'd1);
        send_request(CMD_ADD, 5'd2, 5'd26, 16'd1);
        send_request(CMD_NONE, 5'd31, 5'd31, 16'hFFFF);
        send_request(CMD_SEARCH, 5'd0, 5'd0, 16'd0);
        set_endpoints(5'd25, 5'd0);
        send_request(CMD_SEARCH, 5'd0, 5'd0, 16'd0);
        set_endpoints(5'd2, 5'd2);
        send_request(CMD_SEARCH, 5'd0, 5'd0, 16'd0);
        set_endpoints(5'd31, 5'd2);
        send_request(CMD_SEARCH, 5'd0, 5'd0, 16'd0);
        set_endpoints(5'd0, 5'd30);
        send_request(CMD_SEARCH, 5'd0, 5'd0, 16'd0);
        send_request(CMD_CLEAR, 5'd0, 5'd0, 16'd0);
        set_endpoints(5'd0, 5'd25);
        send_request(CMD_SEARCH, 5'd0, 5'd0, 16'd0);
        wait_idle();
    endtask

    // A long chain through all vertices gives the longest path.
    task automatic test_long_chain();
        for (int v = 0; v < VERTEX_COUNT - 1; v++)
            send_request(CMD_ADD, v[4:0], v[4:0] + 5'd1, 16'($urandom_range(3)));
        send_request(CMD_SEARCH, 5'd0, 5'd0, 16'd0);
        send_request(CMD_CLEAR, 5'd0, 5'd0, 16'd0);
        wait_idle();
    endtask

    // Fills the store past its capacity; the surplus edges must be dropped.
    task automatic test_store_full();
        int fill;
        fill = MAX_EDGES - graph_edges + 4;
        for (int i = 0; i < fill; i++)
            send_request(CMD_ADD, 5'($urandom_range(25)), 5'($urandom_range(25)),
                         16'($urandom));
        send_request(CMD_SEARCH, 5'd0, 5'd0, 16'd0);
        wait_idle();
    endtask

    // Random small graphs with random endpoints, mostly well formed.
    task automatic test_random(input int count);
        int n;
        int pick;
        n = 0;
        while (n < count)
        begin
            set_endpoints(5'($urandom_range(25)), ($urandom_range(15) == 0)
                          ? 5'($urandom_range(31)) : 5'($urandom_range(25)));
            send_request(CMD_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom));
            n++;
            for (int i = $urandom_range(30, 4); i > 0; i--)
            begin
                pick = $urandom_range(99);
                if (pick < 85)
                    send_request(CMD_ADD, 5'($urandom_range(25)), 5'($urandom_range(25)),
                                 ($urandom_range(3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(20)));
                else if (pick < 93)
                    send_request(CMD_ADD, 5'($urandom), 5'($urandom), 16'($urandom));
                else
                    send_request(CMD_NONE, 5'($urandom), 5'($urandom), 16'($urandom));
                n++;
            end
            for (int i = $urandom_range(3, 1); i > 0; i--)
            begin
                send_request(CMD_SEARCH, 5'($urandom), 5'($urandom), 16'($urandom));
                n++;
            end
        end
        wait_idle();
    endtask

    // Stalls the output for a long stretch while searches keep arriving.
    task automatic test_backpressure();
        hold_cycles = 3000;
        for (int i = 0; i < 4; i++)
            send_request(CMD_SEARCH, 5'd0, 5'd0, 16'd0);
        wait_idle();
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_idle);
    end

    always @(posedge clk)
    begin
        path_step_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_path.size() == 0)
            begin
                $display("%0t: unexpected result vertex %0d found %0b last %0b",
                         $time, path_vertex, found, last);
                errors++;
            end
            else
            begin
                want = expected_path.pop_front();
                if (want.vtx !== path_vertex || want.fnd !== found || want.lst !== last)
                begin
                    $display("%0t: expected vertex %0d found %0b last %0b, got %0d %0b %0b",
                             $time, want.vtx, want.fnd, want.lst, path_vertex, found, last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        command = CMD_ADD;
        edge_source = '0;
        edge_target = '0;
        edge_weight = '0;
        out_ready = 1'b0;
        hold_cycles = 0;
        errors = 0;
        cycles = 0;
        graph_edges = 0;
        cfg_start = '0;
        cfg_goal = '0;
        sender_idle = 30;
        receiver_idle = 46;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_long_chain();
        test_backpressure();
        test_random(10);
        sender_idle = 46;
        receiver_idle = 30;
        test_store_full();
        sender_idle = 0;
        receiver_idle = 0;
        test_random(10);
        wait_idle();
        if (errors == 0 && expected_path.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* files.f */
hdl/astar_pkg.sv
hdl/astar_ctrl.sv
hdl/astar_dp.sv
hdl/astar_shortest_path_search.sv
bench/astar_shortest_path_search_tb.sv
